>>> sv/sbmd_pkg.sv
package sbmd_pkg;

  localparam int SHRINK_STEPS = 2;
  localparam int NE           = 2 * (SHRINK_STEPS + 1);
  localparam int NP           = NE / 2;
  localparam int CNT_W        = $clog2(NE + 1);
  localparam int Z_W          = 38;
  localparam int PAIR_W       = Z_W + 1;
  localparam int SUM_W        = Z_W + $clog2(NE);
  localparam int DIV_NW       = 51;
  localparam int DIV_DW       = 21;
  localparam int IN_DATA_W    = 88;
  localparam int IN_USER_W    = 10;
  localparam int OUT_DATA_W   = 56;
  localparam int OUT_USER_W   = 2;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 17;
  localparam logic [21:0] RECIP5 = 22'h333334;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_AREA_TOL   = 3'd0,
    REG_RATIO_TOL  = 3'd1,
    REG_ROW_TOL    = 3'd2,
    REG_FOCAL      = 3'd3,
    REG_BASELINE   = 3'd4,
    REG_CENTER_OFF = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic              match;
    logic [NE-1:0]     pos;
    logic signed [11:0] slx;
    logic signed [11:0] sly;
  } sb1_t;

  typedef struct packed {
    logic              match;
    logic              any;
    logic signed [11:0] slx;
    logic signed [11:0] sly;
  } sb2_t;

  typedef struct packed {
    logic        match;
    logic        any;
    logic [15:0] dep;
    logic        negx;
    logic        negy;
  } sb3_t;

  function automatic logic [10:0] mag12(input logic signed [11:0] v);
    logic [11:0] m;
    m = v[11] ? 12'(-v) : 12'(v);
    return m[10:0];
  endfunction

endpackage

>>> sv/sbmd_div.sv
module sbmd_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [sbmd_pkg::DIV_NW-1:0] num,
  input  logic [sbmd_pkg::DIV_DW-1:0] den,
  output logic [sbmd_pkg::DIV_NW-1:0] quo
);
  import sbmd_pkg::*;

  logic [DIV_DW-1:0] rem_r [DIV_NW];
  logic [DIV_NW-1:0] nq_r  [DIV_NW];
  logic [DIV_DW-1:0] dv_r  [DIV_NW];
  logic [DIV_DW-1:0] rem_nxt [DIV_NW];
  logic [DIV_NW-1:0] nq_nxt  [DIV_NW];
  logic [DIV_DW-1:0] dv_nxt  [DIV_NW];

  always_comb begin
    logic [DIV_DW-1:0] rs;
    logic [DIV_NW-1:0] ns;
    logic [DIV_DW-1:0] ds;
    logic [DIV_DW:0]   t;
    logic              ge;
    for (int s = 0; s < DIV_NW; s++) begin
      if (s == 0) begin
        rs = '0;
        ns = num;
        ds = den;
      end else begin
        rs = rem_r[s-1];
        ns = nq_r[s-1];
        ds = dv_r[s-1];
      end
      t  = {rs, ns[DIV_NW-1]};
      ge = t >= {1'b0, ds};
      rem_nxt[s] = ge ? DIV_DW'(t - {1'b0, ds}) : t[DIV_DW-1:0];
      nq_nxt[s]  = {ns[DIV_NW-2:0], ge};
      dv_nxt[s]  = ds;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_NW; s++) begin
        rem_r[s] <= rem_nxt[s];
        nq_r[s]  <= nq_nxt[s];
        dv_r[s]  <= dv_nxt[s];
      end
    end
  end

  assign quo = nq_r[DIV_NW-1];

endmodule

>>> sv/stereo_box_match_depth_unit.sv
// Stereo box match and depth. Each item is one right/left box pair; the
// block accepts one item every cycle unless the result side stalls, and
// returns one result per item, in order, through three 51-stage restoring
// divider pipelines in series (edge depths, depth average, centroid scaling)
// plus nine stages of compare, multiply and add logic. A stall on the
// result side holds the whole pipeline. The user must keep to this: configuration
// is written while no item is in flight; the block itself does not enforce it.
module stereo_box_match_depth_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // right_left_edge, right_top_edge, right_far_edge, right_bottom_edge,
  // left_left_edge, left_top_edge, left_far_edge, left_bottom_edge
  input  logic [sbmd_pkg::IN_DATA_W-1:0]     in_tdata,
  // right_class, left_class
  input  logic [sbmd_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // depth_mm, x_mm, y_mm, zero pad
  output logic [sbmd_pkg::OUT_DATA_W-1:0]    out_tdata,
  // matched, depth_valid
  output logic [sbmd_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                               cfg_we,
  input  logic [sbmd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [sbmd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sbmd_pkg::*;

  logic [8:0]         atol_r, rtol_r;
  logic [7:0]         rowtol_r;
  logic [11:0]        f_r;
  logic [9:0]         b_r;
  logic signed [16:0] off_r;
  logic [21:0]        fb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atol_r   <= 9'd77;
      rtol_r   <= 9'd77;
      rowtol_r <= 8'd10;
      f_r      <= 12'd874;
      b_r      <= 10'd75;
      off_r    <= 17'sd372;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_AREA_TOL:   atol_r   <= cfg_wdata[8:0];
        REG_RATIO_TOL:  rtol_r   <= cfg_wdata[8:0];
        REG_ROW_TOL:    rowtol_r <= cfg_wdata[7:0];
        REG_FOCAL:      f_r      <= cfg_wdata[11:0];
        REG_BASELINE:   b_r      <= cfg_wdata[9:0];
        REG_CENTER_OFF: off_r    <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    fb_r <= 22'(f_r) * 22'(b_r);
  end

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: box geometry
  logic signed [10:0] rx1, ry1, rx2, ry2, lx1, ly1, lx2, ly2;
  assign rx1 = in_tdata[10:0];
  assign ry1 = in_tdata[21:11];
  assign rx2 = in_tdata[32:22];
  assign ry2 = in_tdata[43:33];
  assign lx1 = in_tdata[54:44];
  assign ly1 = in_tdata[65:55];
  assign lx2 = in_tdata[76:66];
  assign ly2 = in_tdata[87:77];

  logic [10:0]        wr_nxt, hr_nxt, wl_nxt, hl_nxt;
  logic               rowok_nxt;
  logic signed [17:0] v_nxt [NE];
  logic signed [11:0] slx_nxt, sly_nxt;

  always_comb begin
    logic signed [11:0] srs, dxa, dxb;
    logic signed [12:0] rd;
    logic [12:0]        rm;
    wr_nxt  = mag12(12'(rx2) - 12'(rx1));
    hr_nxt  = mag12(12'(ry2) - 12'(ry1));
    wl_nxt  = mag12(12'(lx2) - 12'(lx1));
    hl_nxt  = mag12(12'(ly2) - 12'(ly1));
    slx_nxt = 12'(lx1) + 12'(lx2);
    sly_nxt = 12'(ly1) + 12'(ly2);
    srs     = 12'(ry1) + 12'(ry2);
    rd      = 13'(sly_nxt) - 13'(srs);
    rm      = rd[12] ? 13'(-rd) : 13'(rd);
    rowok_nxt = rm <= {4'b0, rowtol_r, 1'b0};
    dxa = 12'(rx1) - 12'(lx1);
    dxb = 12'(rx2) - 12'(lx2);
    for (int k = 0; k <= SHRINK_STEPS; k++) begin
      v_nxt[2*k]   = 18'(dxa) * $signed({1'b0, 5'(20 + k)});
      v_nxt[2*k+1] = 18'(dxb) * $signed({1'b0, 5'(20 - k)});
    end
  end

  logic [10:0]        wr_r, hr_r, wl_r, hl_r;
  logic               ceq1_r, rowok1_r;
  logic signed [17:0] v_r [NE];
  logic signed [11:0] slx1_r, sly1_r;

  // stage 2: areas, disparity magnitudes
  logic [21:0]        ax2_r [NE];
  logic [NE-1:0]      neg2_r;
  logic [21:0]        ar2_r, al2_r, pr2_r, pl2_r;
  logic               ceq2_r, rowok2_r, nz2_r;
  logic signed [11:0] slx2_r, sly2_r;

  // stage 3: divide by five, area sums
  logic [19:0]        q3_r [NE];
  logic [NE-1:0]      neg3_r;
  logic [21:0]        ad3_r, pd3_r;
  logic [22:0]        as3_r, ps3_r;
  logic               ok3_r;
  logic signed [11:0] slx3_r, sly3_r;

  // stage 4: disparities, tolerance tests
  logic signed [20:0] d4_r [NE];
  logic               ok4_r, aok4_r, pok4_r;
  logic signed [11:0] slx4_r, sly4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wr_r <= wr_nxt;
      hr_r <= hr_nxt;
      wl_r <= wl_nxt;
      hl_r <= hl_nxt;
      ceq1_r   <= in_tuser[4:0] == in_tuser[9:5];
      rowok1_r <= rowok_nxt;
      slx1_r   <= slx_nxt;
      sly1_r   <= sly_nxt;
      for (int e = 0; e < NE; e++) v_r[e] <= v_nxt[e];

      for (int e = 0; e < NE; e++) begin
        logic [17:0] vm;
        vm = v_r[e][17] ? 18'(-v_r[e]) : 18'(v_r[e]);
        ax2_r[e]  <= {vm[15:0], 6'd0} + 22'd2;
        neg2_r[e] <= v_r[e][17];
      end
      ar2_r    <= 22'(wr_r) * 22'(hr_r);
      al2_r    <= 22'(wl_r) * 22'(hl_r);
      pr2_r    <= 22'(hr_r) * 22'(wl_r);
      pl2_r    <= 22'(hl_r) * 22'(wr_r);
      ceq2_r   <= ceq1_r;
      rowok2_r <= rowok1_r;
      nz2_r    <= (wr_r != '0) && (wl_r != '0);
      slx2_r   <= slx1_r;
      sly2_r   <= sly1_r;

      for (int e = 0; e < NE; e++) begin
        logic [43:0] pq;
        pq = 44'(ax2_r[e]) * 44'(RECIP5);
        q3_r[e] <= pq[43:24];
      end
      neg3_r <= neg2_r;
      ad3_r  <= (ar2_r > al2_r) ? ar2_r - al2_r : al2_r - ar2_r;
      pd3_r  <= (pr2_r > pl2_r) ? pr2_r - pl2_r : pl2_r - pr2_r;
      as3_r  <= 23'(ar2_r) + 23'(al2_r);
      ps3_r  <= 23'(pr2_r) + 23'(pl2_r);
      ok3_r  <= ceq2_r && rowok2_r && nz2_r;
      slx3_r <= slx2_r;
      sly3_r <= sly2_r;

      for (int e = 0; e < NE; e++) begin
        logic signed [20:0] qs;
        qs = $signed({1'b0, q3_r[e]});
        d4_r[e] <= (neg3_r[e] ? -qs : qs) + 21'(off_r);
      end
      ok4_r  <= ok3_r;
      aok4_r <= (as3_r != '0) && ({2'b0, ad3_r, 8'd0} <= 32'(atol_r) * 32'(as3_r));
      pok4_r <= (ps3_r != '0) && ({2'b0, pd3_r, 8'd0} <= 32'(rtol_r) * 32'(ps3_r));
      slx4_r <= slx3_r;
      sly4_r <= sly3_r;
    end
  end

  // edge depth dividers
  logic [NE-1:0]     pos4;
  logic [DIV_NW-1:0] q1 [NE];
  sb1_t              sb1_in;

  always_comb begin
    for (int e = 0; e < NE; e++) pos4[e] = !d4_r[e][20] && (d4_r[e] != '0);
    sb1_in.match = ok4_r && aok4_r && pok4_r;
    sb1_in.pos   = pos4;
    sb1_in.slx   = slx4_r;
    sb1_in.sly   = sly4_r;
  end

  for (genvar e = 0; e < NE; e++) begin : g_edge
    sbmd_div u_div (
      .clk (clk),
      .en  (en),
      .num (pos4[e] ? DIV_NW'({fb_r, 16'd0}) : DIV_NW'(0)),
      .den (pos4[e] ? DIV_DW'(d4_r[e]) : DIV_DW'(1)),
      .quo (q1[e])
    );
  end

  sb1_t l1_r [DIV_NW];

  // average
  logic [PAIR_W-1:0] pair_r [NP];
  logic [CNT_W-1:0]  cnt_a1_r, cnt_a2_r;
  sb1_t              a1_r, a2_r;
  logic [SUM_W-1:0]  tot_r;

  // centroid products
  logic [DIV_NW-1:0]  q2;
  sb2_t               l2_r [DIV_NW];
  sb2_t               sb2_in;
  logic [15:0]        dep_p1_r;
  logic signed [51:0] xn_r;
  logic signed [50:0] yn_r;
  logic               match_p1_r, any_p1_r;
  logic [DIV_NW-1:0]  nx_r, ny_r;
  sb3_t               p2_r;
  sb3_t               l3_r [DIV_NW];

  always_comb begin
    sb2_in.match = a2_r.match;
    sb2_in.any   = cnt_a2_r != '0;
    sb2_in.slx   = a2_r.slx;
    sb2_in.sly   = a2_r.sly;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_r[0] <= sb1_in;
      for (int i = 1; i < DIV_NW; i++) l1_r[i] <= l1_r[i-1];

      for (int j = 0; j < NP; j++) begin
        pair_r[j] <= PAIR_W'(q1[2*j][Z_W-1:0]) + PAIR_W'(q1[2*j+1][Z_W-1:0]);
      end
      cnt_a1_r <= CNT_W'($countones(l1_r[DIV_NW-1].pos));
      a1_r     <= l1_r[DIV_NW-1];

      begin
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int j = 0; j < NP; j++) acc = acc + SUM_W'(pair_r[j]);
        tot_r <= acc;
      end
      cnt_a2_r <= cnt_a1_r;
      a2_r     <= a1_r;

      l2_r[0] <= sb2_in;
      for (int i = 1; i < DIV_NW; i++) l2_r[i] <= l2_r[i-1];

      begin
        logic [Z_W-1:0]     z;
        logic [Z_W:0]       zr;
        logic signed [Z_W:0] zs;
        z  = q2[Z_W-1:0];
        zr = (Z_W+1)'(z) + (Z_W+1)'(128);
        zs = $signed({1'b0, z});
        dep_p1_r   <= (zr[Z_W:8] > (Z_W-7)'(65535)) ? 16'hFFFF : zr[23:8];
        xn_r       <= 52'(zs) * 52'(l2_r[DIV_NW-1].slx) + $signed({22'd0, fb_r, 8'd0});
        yn_r       <= 51'(zs) * 51'(l2_r[DIV_NW-1].sly);
        match_p1_r <= l2_r[DIV_NW-1].match;
        any_p1_r   <= l2_r[DIV_NW-1].any;
      end

      begin
        logic [51:0] mx;
        logic [50:0] my;
        mx = xn_r[51] ? 52'(-xn_r) : 52'(xn_r);
        my = yn_r[50] ? 51'(-yn_r) : 51'(yn_r);
        nx_r <= mx[DIV_NW-1:0] + DIV_NW'({f_r, 8'd0});
        ny_r <= my + DIV_NW'({f_r, 8'd0});
        p2_r.match <= match_p1_r;
        p2_r.any   <= any_p1_r;
        p2_r.dep   <= dep_p1_r;
        p2_r.negx  <= xn_r[51];
        p2_r.negy  <= yn_r[50];
      end

      l3_r[0] <= p2_r;
      for (int i = 1; i < DIV_NW; i++) l3_r[i] <= l3_r[i-1];
    end
  end

  sbmd_div u_avg (
    .clk (clk),
    .en  (en),
    .num (DIV_NW'(tot_r)),
    .den ((cnt_a2_r != '0) ? DIV_DW'(cnt_a2_r) : DIV_DW'(1)),
    .quo (q2)
  );

  logic [DIV_NW-1:0] qx, qy;

  sbmd_div u_xdiv (
    .clk (clk),
    .en  (en),
    .num (nx_r),
    .den ({f_r, 9'd0}),
    .quo (qx)
  );

  sbmd_div u_ydiv (
    .clk (clk),
    .en  (en),
    .num (ny_r),
    .den ({f_r, 9'd0}),
    .quo (qy)
  );

  // output register
  logic [16:0] xs, ys;
  sb3_t        fin;

  always_comb begin
    fin = l3_r[DIV_NW-1];
    if (fin.negx) xs = (qx > DIV_NW'(65536)) ? 17'h10000 : 17'(-qx[16:0]);
    else          xs = (qx > DIV_NW'(65535)) ? 17'h0FFFF : qx[16:0];
    if (fin.negy) ys = (qy > DIV_NW'(65536)) ? 17'h10000 : 17'(-qy[16:0]);
    else          ys = (qy > DIV_NW'(65535)) ? 17'h0FFFF : qy[16:0];
    if (f_r == '0) begin
      xs = '0;
      ys = '0;
    end
  end

  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (fin.match && fin.any) begin
        out_data_r <= {6'd0, ys, xs, fin.dep};
        out_user_r <= 2'b11;
      end else begin
        out_data_r <= '0;
        out_user_r <= {1'b0, fin.match};
      end
    end
  end

  logic v1_r, v2_r, v3_r, v4_r, va1_r, va2_r, vp1_r, vp2_r;
  logic [DIV_NW-1:0] vl1_r, vl2_r, vl3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vl1_r <= '0;
      va1_r <= 1'b0;
      va2_r <= 1'b0;
      vl2_r <= '0;
      vp1_r <= 1'b0;
      vp2_r <= 1'b0;
      vl3_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_tvalid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      vl1_r <= {vl1_r[DIV_NW-2:0], v4_r};
      va1_r <= vl1_r[DIV_NW-1];
      va2_r <= va1_r;
      vl2_r <= {vl2_r[DIV_NW-2:0], va2_r};
      vp1_r <= vl2_r[DIV_NW-1];
      vp2_r <= vp1_r;
      vl3_r <= {vl3_r[DIV_NW-2:0], vp2_r};
      out_valid_r <= vl3_r[DIV_NW-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_nomatch_nodepth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> !out_tuser[1])
    else $error("depth flagged on unmatched pair");

  a_nodepth_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata == '0)
    else $error("nonzero payload without depth");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule
